/* design/ifda_pkg.sv */
// shared types and constants for the imu fifo decimating average block
package ifda_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int AXES           = 3;
  localparam int DECIMATION_DEF = 4;

  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_GYRO  = 2'd1;

  localparam logic SENSOR_ACCEL = 1'b0;
  localparam logic SENSOR_GYRO  = 1'b1;

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [SAMPLE_W-1:0] x_value;
    logic signed [SAMPLE_W-1:0] y_value;
    logic signed [SAMPLE_W-1:0] z_value;
  } in_item_t;

  typedef struct packed {
    logic                       sensor;
    logic signed [SAMPLE_W-1:0] x_average;
    logic signed [SAMPLE_W-1:0] y_average;
    logic signed [SAMPLE_W-1:0] z_average;
  } out_item_t;

  // accumulate strobe, gyro select and group-last flag sent from the top to every axis lane
  typedef struct packed {
    logic acc_en;
    logic gyro;
    logic last;
  } lane_ctrl_t;

endpackage

/* design/ifda_lane.sv */
// one axis lane: accel and gyro running sums, captures the finished sum magnitude and sign
module ifda_lane #(
  parameter int DECIMATION = ifda_pkg::DECIMATION_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  ifda_pkg::lane_ctrl_t                             ctrl,
  input  logic signed [ifda_pkg::SAMPLE_W-1:0]             sample,
  output logic [ifda_pkg::SAMPLE_W+$clog2(DECIMATION)-1:0] mag_r,
  output logic                                             neg_r
);
  import ifda_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(DECIMATION);

  logic signed [SUM_W-1:0] accel_sum_r, accel_sum_nxt;
  logic signed [SUM_W-1:0] gyro_sum_r, gyro_sum_nxt;
  logic signed [SUM_W-1:0] sum_sel;
  logic signed [SUM_W-1:0] total;
  logic signed [SUM_W-1:0] sample_ext;

  assign sample_ext = SUM_W'(sample);
  assign sum_sel    = ctrl.gyro ? gyro_sum_r : accel_sum_r;
  assign total      = sum_sel + sample_ext;

  always_comb begin
    accel_sum_nxt = accel_sum_r;
    gyro_sum_nxt  = gyro_sum_r;
    if (ctrl.acc_en) begin
      if (ctrl.gyro) begin
        gyro_sum_nxt = ctrl.last ? '0 : total;
      end else begin
        accel_sum_nxt = ctrl.last ? '0 : total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_sum_r <= '0;
      gyro_sum_r  <= '0;
    end else begin
      accel_sum_r <= accel_sum_nxt;
      gyro_sum_r  <= gyro_sum_nxt;
    end
  end

  // magnitude and sign so the divide truncates toward zero
  always_ff @(posedge clk) begin
    if (ctrl.acc_en && ctrl.last) begin
      mag_r <= total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
      neg_r <= total[SUM_W-1];
    end
  end

endmodule

/* design/ifda_merge.sv */
// merge stage: divides each lane sum by the decimation factor and holds the result item
module ifda_merge #(
  parameter int DECIMATION = ifda_pkg::DECIMATION_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             s1_valid,
  input  logic                                             s1_sensor,
  input  logic [ifda_pkg::SAMPLE_W+$clog2(DECIMATION)-1:0] mag [ifda_pkg::AXES],
  input  logic                                             neg [ifda_pkg::AXES],
  output logic                                             adv,
  output logic                                             out_valid_r,
  input  logic                                             out_ready,
  output ifda_pkg::out_item_t                              out_data_r
);
  import ifda_pkg::*;

  localparam int LOG_D = $clog2(DECIMATION);
  localparam int SUM_W = SAMPLE_W + LOG_D;
  localparam int SHIFT = SUM_W + LOG_D;
  localparam int PROD_W = SUM_W + SHIFT;
  // ceil(2^SHIFT / DECIMATION), exact quotient for any SUM_W-bit magnitude
  localparam logic [SHIFT-1:0] RECIP =
    SHIFT'(((64'd1 << SHIFT) + 64'(DECIMATION) - 64'd1) / 64'(DECIMATION));

  logic [PROD_W-1:0]          prod [AXES];
  logic [SAMPLE_W-1:0]        quot [AXES];
  logic signed [SAMPLE_W-1:0] avg  [AXES];
  out_item_t                  out_data_nxt;

  assign adv = !out_valid_r || out_ready;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      prod[a] = PROD_W'(mag[a]) * PROD_W'(RECIP);
      quot[a] = prod[a][SHIFT +: SAMPLE_W];
      avg[a]  = neg[a] ? SAMPLE_W'(-quot[a]) : quot[a];
    end
    out_data_nxt.sensor    = s1_sensor;
    out_data_nxt.x_average = avg[0];
    out_data_nxt.y_average = avg[1];
    out_data_nxt.z_average = avg[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* design/imu_fifo_decimating_average_top.sv */
// top level of the imu fifo decimating average block
// result path: lane magnitude and sign registers, then the merge result register
// throughput: 1 item per cycle; an item is taken every cycle while the result side keeps up
// the add per axis in each lane and the reciprocal multiply in the merge stage set that figure
// reset: synchronous active low, clears all sums, both counts and both valid flags
module imu_fifo_decimating_average_top #(
  parameter int DECIMATION = ifda_pkg::DECIMATION_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ifda_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ifda_pkg::out_item_t out_data
);
  import ifda_pkg::*;

  localparam int CNT_W = $clog2(DECIMATION);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DECIMATION - 1);

  logic                    in_acc;
  logic                    is_accel;
  logic                    is_gyro;
  logic                    last_hit;
  logic [CNT_W-1:0]        accel_cnt_r, accel_cnt_nxt;
  logic [CNT_W-1:0]        gyro_cnt_r, gyro_cnt_nxt;
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_sensor_r;
  logic                    adv;
  lane_ctrl_t              ctrl;
  logic signed [SAMPLE_W-1:0] samples [AXES];
  logic [SUM_W-1:0]        mag [AXES];
  logic                    neg [AXES];

  assign in_ready = !s1_valid_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign is_accel = in_data.kind == KIND_ACCEL;
  assign is_gyro  = in_data.kind == KIND_GYRO;
  assign last_hit = is_gyro ? (gyro_cnt_r == CNT_LAST) : (accel_cnt_r == CNT_LAST);

  assign ctrl.acc_en = in_acc && (is_accel || is_gyro);
  assign ctrl.gyro   = is_gyro;
  assign ctrl.last   = last_hit;

  assign samples[0] = in_data.x_value;
  assign samples[1] = in_data.y_value;
  assign samples[2] = in_data.z_value;

  always_comb begin
    accel_cnt_nxt = accel_cnt_r;
    gyro_cnt_nxt  = gyro_cnt_r;
    if (ctrl.acc_en) begin
      if (is_gyro) begin
        gyro_cnt_nxt = last_hit ? '0 : gyro_cnt_r + CNT_W'(1);
      end else begin
        accel_cnt_nxt = last_hit ? '0 : accel_cnt_r + CNT_W'(1);
      end
    end
    s1_valid_nxt = s1_valid_r;
    if (ctrl.acc_en && last_hit) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_cnt_r <= '0;
      gyro_cnt_r  <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      accel_cnt_r <= accel_cnt_nxt;
      gyro_cnt_r  <= gyro_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc_en && last_hit) begin
      s1_sensor_r <= is_gyro ? SENSOR_GYRO : SENSOR_ACCEL;
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    ifda_lane #(
      .DECIMATION(DECIMATION)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .sample(samples[g]),
      .mag_r (mag[g]),
      .neg_r (neg[g])
    );
  end

  ifda_merge #(
    .DECIMATION(DECIMATION)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_sensor  (s1_sensor_r),
    .mag        (mag),
    .neg        (neg),
    .adv        (adv),
    .out_valid_r(out_valid),
    .out_ready  (out_ready),
    .out_data_r (out_data)
  );

endmodule

/* design/ifda_checker.sv */
// port level checks for the imu fifo decimating average block, bound to the top level
module ifda_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ifda_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ifda_pkg::out_item_t out_data
);
  import ifda_pkg::*;

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // input side never stalls while the result side can move
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("in_ready low while result side free");

  // an item taken at the input never makes the result register drop an unread item
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> out_valid)
    else $error("result item lost on input accept");

endmodule

bind imu_fifo_decimating_average_top ifda_checker u_ifda_checker (.*);

/* tb/tb_imu_fifo_decimating_average_top.sv */
// testbench for the imu fifo decimating average block: directed and random words, scoreboard check
`timescale 1ns / 100ps

module tb_imu_fifo_decimating_average_top;
  import ifda_pkg::*;

  localparam int DECIM = DECIMATION_DEF;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int REPORT_MAX = 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // per-sensor running sums and counts, expected averages in arrival order
  class decim_scoreboard;
    int sums[2*AXES];
    int count[2];
    out_item_t avg_q[$];
    int mismatches;

    function new();
      foreach (sums[i]) sums[i] = 0;
      count[0] = 0;
      count[1] = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return avg_q.size();
    endfunction

    function void note_input(in_item_t it);
      int s[AXES];
      int sel;
      out_item_t avg;
      if (it.kind != KIND_ACCEL && it.kind != KIND_GYRO) return;
      s[0] = it.x_value;
      s[1] = it.y_value;
      s[2] = it.z_value;
      sel = (it.kind == KIND_GYRO) ? 1 : 0;
      for (int a = 0; a < AXES; a++) sums[sel*AXES+a] += s[a];
      count[sel]++;
      if (count[sel] < DECIM) return;
      avg.sensor = sel ? SENSOR_GYRO : SENSOR_ACCEL;
      // int division truncates toward zero
      avg.x_average = sample_t'(sums[sel*AXES+0] / DECIM);
      avg.y_average = sample_t'(sums[sel*AXES+1] / DECIM);
      avg.z_average = sample_t'(sums[sel*AXES+2] / DECIM);
      for (int a = 0; a < AXES; a++) sums[sel*AXES+a] = 0;
      count[sel] = 0;
      avg_q.push_back(avg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_avg;
      if (avg_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result item sensor=%0d avg=(%0d,%0d,%0d)", $realtime,
                   got.sensor, got.x_average, got.y_average, got.z_average);
        return;
      end
      exp_avg = avg_q.pop_front();
      if (got.sensor !== exp_avg.sensor || got.x_average !== exp_avg.x_average ||
          got.y_average !== exp_avg.y_average || got.z_average !== exp_avg.z_average) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: expected sensor=%0d avg=(%0d,%0d,%0d) got sensor=%0d avg=(%0d,%0d,%0d)",
                   $realtime, exp_avg.sensor, exp_avg.x_average, exp_avg.y_average,
                   exp_avg.z_average, got.sensor, got.x_average, got.y_average, got.z_average);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  decim_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int quiet_cycles;

  imu_fifo_decimating_average_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // both sides observed at the same edge, inputs noted before results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, or one long hold when asked
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic directed_word(input logic [1:0] k, input int x, input int y, input int z);
    in_item_t it;
    it.kind = k;
    it.x_value = sample_t'(x);
    it.y_value = sample_t'(y);
    it.z_value = sample_t'(z);
    send_word(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(7))
      0: return sample_t'(-32768);
      1: return sample_t'(32767);
      2: return sample_t'($urandom_range(8)) - sample_t'(4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_word();
    in_item_t it;
    int r;
    r = $urandom_range(99);
    if (r < 45) it.kind = KIND_ACCEL;
    else if (r < 90) it.kind = KIND_GYRO;
    else if (r < 95) it.kind = KIND_OTHER;
    else it.kind = KIND_UNUSED;
    it.x_value = random_sample();
    it.y_value = random_sample();
    it.z_value = random_sample();
    return it;
  endfunction

  // ignored tags do not count toward n_words
  task automatic random_phase(input int n_words, input int idle_pct, input int stall_pct);
    in_item_t it;
    int n;
    n = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (n < n_words) begin
      it = random_word();
      send_word(it);
      if (it.kind == KIND_ACCEL || it.kind == KIND_GYRO) n++;
    end
    wait_drained();
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // accel extremes; z sums to -3 so truncation toward zero gives 0
    directed_word(KIND_ACCEL, -32768, 32767, -1);
    directed_word(KIND_ACCEL, -32768, 32767, -1);
    directed_word(KIND_ACCEL, -32768, 32767, -1);
    directed_word(KIND_OTHER, -1, -1, -1);
    directed_word(KIND_UNUSED, -32768, -32768, -32768);
    directed_word(KIND_ACCEL, -32768, 32767, 0);
    // interleaved sensors, extremes and small negative sums
    directed_word(KIND_GYRO, 32767, -32768, 1);
    directed_word(KIND_ACCEL, -5, 5, -7);
    directed_word(KIND_GYRO, 32767, -32768, 1);
    directed_word(KIND_ACCEL, 0, 0, 0);
    directed_word(KIND_GYRO, 32767, -32768, 1);
    directed_word(KIND_ACCEL, 0, 0, 0);
    directed_word(KIND_UNUSED, 32767, 32767, 32767);
    directed_word(KIND_ACCEL, 0, 0, 0);
    directed_word(KIND_GYRO, 32767, -32768, 0);
    directed_word(KIND_OTHER, 0, 0, 0);
    directed_word(KIND_GYRO, -1, 1, -32768);
    directed_word(KIND_GYRO, -1, 1, -32768);
    directed_word(KIND_GYRO, -1, 1, -32768);
    directed_word(KIND_GYRO, -2, 2, -32768);
    wait_drained();

    random_phase(400, 0, 0);
    random_phase(400, 50, 0);
    // long hold on the result side while items keep coming
    hold_req = 1'b1;
    random_phase(60, 0, 0);
    random_phase(400, 0, 50);
    random_phase(300, 17, 17);

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
